/* design/mgrv_pkg.sv */
// ----------------------------------------------------------------------------
// mgrv_pkg: shared types and constants for the multigrid rhomb vertex block
// Fixed-point widths, multiply-accumulate control, and the sine/cosine table.
// ----------------------------------------------------------------------------
`default_nettype none

package mgrv_pkg;

  // Fixed-point format and internal widths
  localparam int FRAC_BITS  = 12;
  localparam int MAX_DIRS   = 16;
  localparam int TRIG_W     = 14;
  localparam int OPA_W      = 25;
  localparam int ACC_W      = 40;
  localparam int DEN_W      = 27;
  localparam int QUOT_W     = 24;
  localparam int ROM_DEPTH  = MAX_DIRS * MAX_DIRS;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [OPA_W-1:0]  opa_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [DEN_W-1:0]  den_t;
  typedef logic signed [QUOT_W-1:0] quot_t;

  // Accumulator base selection codes
  localparam logic [1:0] BASE_ACC  = 2'd0;
  localparam logic [1:0] BASE_ZERO = 2'd1;
  localparam logic [1:0] BASE_EXT  = 2'd2;

  typedef struct packed {
    logic       en;
    logic [1:0] base_sel;
    logic       neg;
  } mac_ctrl_t;

  typedef logic [2*TRIG_W-1:0] trig_rom_t [ROM_DEPTH];

  // Unsigned quotient by shift and subtract, used while building the table.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[62:0], num[k]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds {sin, cos} in Q.12 for every direction count (1..16) and direction.
  // Evaluated once at elaboration.
  function automatic trig_rom_t build_trig();
    trig_rom_t           rom;
    longint unsigned     x;
    longint unsigned     x2;
    longint unsigned     ts;
    longint unsigned     tc;
    longint unsigned     nn;
    longint unsigned     mag;
    longint signed       s;
    longint signed       c;
    longint signed       sv;
    longint signed       cv;
    longint signed       so;
    longint signed       co;
    int unsigned         nd;
    int unsigned         d;
    int unsigned         q;
    int unsigned         r;
    int unsigned         i;
    for (nd = 1; nd <= MAX_DIRS; nd++) begin
      for (d = 0; d < MAX_DIRS; d++) begin
        q  = 32'(udiv64(64'(4 * d), 64'(nd)));
        r  = 4 * d - q * nd;
        x  = udiv64(64'd1686629713 * longint'(r), 64'(nd));
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        s  = longint'(x);
        c  = longint'(64'd1 << 30);
        for (i = 1; i <= 9; i++) begin
          nn = 2 * i;
          ts = udiv64((ts * x2) >> 30, nn * (nn + 1));
          tc = udiv64((tc * x2) >> 30, (nn - 1) * nn);
          if (i % 2 == 1) begin
            s = s - longint'(ts);
            c = c - longint'(tc);
          end else begin
            s = s + longint'(ts);
            c = c + longint'(tc);
          end
        end
        mag = (s < 0) ? longint'(-s) : longint'(s);
        mag = (mag + (64'd1 << 17)) >> 18;
        sv  = (s < 0) ? -longint'(mag) : longint'(mag);
        mag = (c < 0) ? longint'(-c) : longint'(c);
        mag = (mag + (64'd1 << 17)) >> 18;
        cv  = (c < 0) ? -longint'(mag) : longint'(mag);
        case (q % 4)
          0: begin so = sv;  co = cv;  end
          1: begin so = cv;  co = -sv; end
          2: begin so = -sv; co = -cv; end
          default: begin so = -cv; co = sv; end
        endcase
        rom[(nd - 1) * MAX_DIRS + d] = {so[TRIG_W-1:0], co[TRIG_W-1:0]};
      end
    end
    return rom;
  endfunction

  localparam trig_rom_t TRIG_ROM = build_trig();

endpackage

`default_nettype wire

/* design/multigrid_rhomb_vertices.sv */
// ----------------------------------------------------------------------------
// multigrid_rhomb_vertices: rhomb corners of a de Bruijn multigrid tiling
// Intersects two grid lines, indexes every other direction, and sums corners.
// ----------------------------------------------------------------------------
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | dir_first, dir_second, lines
//   out_    | output    | out_valid/out_stall | hit, four vertex x/y
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each item takes two divider waits and a pass of the shared multiplier over
// the other directions. An invalid pair goes straight to the done state.
// Reset is synchronous, active low, and restores the register defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module multigrid_rhomb_vertices (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_dir_first,
  input  wire logic [3:0]         in_dir_second,
  input  wire logic signed [5:0]  in_line_first,
  input  wire logic signed [5:0]  in_line_second,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic signed [22:0]      out_vert0_x,
  output logic signed [22:0]      out_vert0_y,
  output logic signed [22:0]      out_vert1_x,
  output logic signed [22:0]      out_vert1_y,
  output logic signed [22:0]      out_vert2_x,
  output logic signed [22:0]      out_vert2_y,
  output logic signed [22:0]      out_vert3_x,
  output logic signed [22:0]      out_vert3_y,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [13:0]        cfg_data
);
  import mgrv_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
  localparam logic [ST_W-1:0] ST_TRA  = 5'd1;
  localparam logic [ST_W-1:0] ST_TRB  = 5'd2;
  localparam logic [ST_W-1:0] ST_DEN0 = 5'd3;
  localparam logic [ST_W-1:0] ST_DEN1 = 5'd4;
  localparam logic [ST_W-1:0] ST_NX0  = 5'd5;
  localparam logic [ST_W-1:0] ST_NX1  = 5'd6;
  localparam logic [ST_W-1:0] ST_DIVX = 5'd7;
  localparam logic [ST_W-1:0] ST_NY0  = 5'd8;
  localparam logic [ST_W-1:0] ST_NY1  = 5'd9;
  localparam logic [ST_W-1:0] ST_DIVY = 5'd10;
  localparam logic [ST_W-1:0] ST_T10  = 5'd11;
  localparam logic [ST_W-1:0] ST_T11  = 5'd12;
  localparam logic [ST_W-1:0] ST_T20  = 5'd13;
  localparam logic [ST_W-1:0] ST_T21  = 5'd14;
  localparam logic [ST_W-1:0] ST_P0   = 5'd15;
  localparam logic [ST_W-1:0] ST_P1   = 5'd16;
  localparam logic [ST_W-1:0] ST_P2   = 5'd17;
  localparam logic [ST_W-1:0] ST_P3   = 5'd18;
  localparam logic [ST_W-1:0] ST_VX0  = 5'd19;
  localparam logic [ST_W-1:0] ST_VX1  = 5'd20;
  localparam logic [ST_W-1:0] ST_VY0  = 5'd21;
  localparam logic [ST_W-1:0] ST_VY1  = 5'd22;
  localparam logic [ST_W-1:0] ST_DONE = 5'd23;

  localparam logic [1:0] REG_DIR_COUNT = 2'd0;
  localparam logic [1:0] REG_HALF      = 2'd1;
  localparam logic [1:0] REG_OFFSET    = 2'd2;

  localparam int VERT_W = 23;
  localparam int K_W    = 19;
  localparam int IDX_W  = 14;
  localparam int DIR_W  = $clog2(MAX_DIRS + 1);
  localparam int SH2F   = 2 * FRAC_BITS;

  // Configuration registers
  logic [4:0]         dir_count_r;
  logic [4:0]         half_r;
  logic signed [13:0] offset_r;

  // Item state
  logic [ST_W-1:0]    state_r, state_nxt;
  logic [3:0]         a_r, a_nxt, b_r, b_nxt;
  logic signed [5:0]  ja_r, ja_nxt, jb_r, jb_nxt;
  trig_t              sa_r, sa_nxt, ca_r, ca_nxt, sb_r, sb_nxt, cb_r, cb_nxt;
  den_t               den_r, den_nxt;
  quot_t              x_r, x_nxt, y_r, y_nxt;
  acc_t               bx_r, bx_nxt, by_r, by_nxt;
  logic signed [IDX_W-1:0] idx_r, idx_nxt;
  logic [DIR_W-1:0]   d_r, d_nxt;
  logic               hit_r, hit_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic signed [VERT_W-1:0] ov_r [8];
  logic signed [VERT_W-1:0] ov_nxt [8];
  logic               out_load;

  // Datapath helpers
  logic [DIR_W-1:0]   n_sat;
  logic [3:0]         n_m1;
  logic [3:0]         rom_dir;
  logic [ROM_AW-1:0]  rom_idx;
  logic [2*TRIG_W-1:0] rom_word;
  trig_t              rom_sin, rom_cos;
  logic signed [K_W-1:0] k1, k2;
  acc_t               off_base;
  acc_t               lim;
  logic               t_bad;
  logic               in_ok;
  logic signed [6:0]  h_s;

  mac_ctrl_t          mac_ctrl;
  opa_t               op_a;
  trig_t              op_b;
  acc_t               ext_base;
  acc_t               sum;

  logic               div_start;
  logic               div_done;
  quot_t              div_quot;

  // Configuration writes, taken in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_count_r <= 5'd5;
      half_r      <= 5'd5;
      offset_r    <= 14'sd819;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIR_COUNT: dir_count_r <= cfg_data[4:0];
        REG_HALF:      half_r      <= cfg_data[4:0];
        REG_OFFSET:    offset_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Direction count saturates at the table size
  assign n_sat = (dir_count_r > 5'(MAX_DIRS)) ? DIR_W'(MAX_DIRS) : DIR_W'(dir_count_r);
  assign n_m1  = 4'(n_sat - DIR_W'(1));
  assign h_s   = 7'(half_r);

  // Pair check at input transfer
  assign in_ok = (in_dir_first < in_dir_second) && (DIR_W'(in_dir_second) < n_sat) &&
                 (7'(in_line_first) <= h_s) && (7'(in_line_first) >= -h_s) &&
                 (7'(in_line_second) <= h_s) && (7'(in_line_second) >= -h_s);

  // Sine/cosine lookup for the direction in use
  always_comb begin
    priority case (state_r)
      ST_TRA:  rom_dir = a_r;
      ST_TRB:  rom_dir = b_r;
      default: rom_dir = d_r[3:0];
    endcase
  end
  assign rom_idx  = {n_m1, rom_dir};
  assign rom_word = TRIG_ROM[rom_idx];
  assign rom_sin  = trig_t'(rom_word[2*TRIG_W-1:TRIG_W]);
  assign rom_cos  = trig_t'(rom_word[TRIG_W-1:0]);

  // Line constants and limits
  assign k1       = (K_W'(ja_r) <<< FRAC_BITS) + K_W'(offset_r);
  assign k2       = (K_W'(jb_r) <<< FRAC_BITS) + K_W'(offset_r);
  assign off_base = -(acc_t'(offset_r) <<< FRAC_BITS);
  assign lim      = acc_t'({1'b0, 5'(half_r), 1'b1}) <<< SH2F;
  assign t_bad    = (sum > lim) || (sum < -lim);

  // Operand selection for the shared multiplier
  always_comb begin
    mac_ctrl = '{en: 1'b1, base_sel: BASE_ZERO, neg: 1'b0};
    op_a     = '0;
    op_b     = '0;
    ext_base = bx_r;
    unique case (state_r)
      ST_DEN0: begin op_a = opa_t'(sa_r); op_b = cb_r; end
      ST_DEN1: begin
        op_a = opa_t'(ca_r); op_b = sb_r;
        mac_ctrl.base_sel = BASE_ACC; mac_ctrl.neg = 1'b1;
      end
      ST_NX0:  begin op_a = opa_t'(k1); op_b = cb_r; end
      ST_NX1:  begin
        op_a = opa_t'(k2); op_b = ca_r;
        mac_ctrl.base_sel = BASE_ACC; mac_ctrl.neg = 1'b1;
      end
      ST_NY0:  begin op_a = opa_t'(k2); op_b = sa_r; end
      ST_NY1:  begin
        op_a = opa_t'(k1); op_b = sb_r;
        mac_ctrl.base_sel = BASE_ACC; mac_ctrl.neg = 1'b1;
      end
      ST_T10:  begin op_a = opa_t'(x_r); op_b = ca_r; end
      ST_T11:  begin
        op_a = opa_t'(y_r); op_b = sa_r;
        mac_ctrl.base_sel = BASE_ACC; mac_ctrl.neg = 1'b1;
      end
      ST_T20:  begin op_a = opa_t'(x_r); op_b = cb_r; end
      ST_T21:  begin
        op_a = opa_t'(y_r); op_b = sb_r;
        mac_ctrl.base_sel = BASE_ACC; mac_ctrl.neg = 1'b1;
      end
      ST_P0:   begin
        op_a = opa_t'(x_r); op_b = rom_sin;
        mac_ctrl.base_sel = BASE_EXT; ext_base = off_base;
      end
      ST_P1:   begin
        op_a = opa_t'(y_r); op_b = rom_cos; mac_ctrl.base_sel = BASE_ACC;
      end
      ST_P2:   begin
        op_a = opa_t'(idx_r); op_b = rom_cos;
        mac_ctrl.base_sel = BASE_EXT; ext_base = bx_r;
      end
      ST_P3:   begin
        op_a = opa_t'(idx_r); op_b = rom_sin;
        mac_ctrl.base_sel = BASE_EXT; ext_base = by_r;
      end
      ST_VX0:  begin
        op_a = opa_t'(ja_r); op_b = ca_r;
        mac_ctrl.base_sel = BASE_EXT; ext_base = bx_r;
      end
      ST_VX1:  begin
        op_a = opa_t'(jb_r); op_b = cb_r; mac_ctrl.base_sel = BASE_ACC;
      end
      ST_VY0:  begin
        op_a = opa_t'(ja_r); op_b = sa_r;
        mac_ctrl.base_sel = BASE_EXT; ext_base = by_r;
      end
      ST_VY1:  begin
        op_a = opa_t'(jb_r); op_b = sb_r; mac_ctrl.base_sel = BASE_ACC;
      end
      default: mac_ctrl.en = 1'b0;
    endcase
  end

  mgrv_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .op_a     (op_a),
    .op_b     (op_b),
    .ext_base (ext_base),
    .sum      (sum)
  );

  assign div_start = (state_r == ST_NX1) || (state_r == ST_NY1);

  mgrv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ja_nxt    = ja_r;
    jb_nxt    = jb_r;
    sa_nxt    = sa_r;
    ca_nxt    = ca_r;
    sb_nxt    = sb_r;
    cb_nxt    = cb_r;
    den_nxt   = den_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    idx_nxt   = idx_r;
    d_nxt     = d_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          a_nxt   = in_dir_first;
          b_nxt   = in_dir_second;
          ja_nxt  = in_line_first;
          jb_nxt  = in_line_second;
          hit_nxt = 1'b0;
          state_nxt = in_ok ? ST_TRA : ST_DONE;
        end
      end
      ST_TRA: begin
        sa_nxt = rom_sin; ca_nxt = rom_cos; state_nxt = ST_TRB;
      end
      ST_TRB: begin
        sb_nxt = rom_sin; cb_nxt = rom_cos; state_nxt = ST_DEN0;
      end
      ST_DEN0: state_nxt = ST_DEN1;
      ST_DEN1: begin
        den_nxt   = sum[DEN_W-1:0];
        state_nxt = (sum == '0) ? ST_DONE : ST_NX0;
      end
      ST_NX0:  state_nxt = ST_NX1;
      ST_NX1:  state_nxt = ST_DIVX;
      ST_DIVX: begin
        if (div_done) begin
          x_nxt = div_quot; state_nxt = ST_NY0;
        end
      end
      ST_NY0:  state_nxt = ST_NY1;
      ST_NY1:  state_nxt = ST_DIVY;
      ST_DIVY: begin
        if (div_done) begin
          y_nxt = div_quot; state_nxt = ST_T10;
        end
      end
      ST_T10:  state_nxt = ST_T11;
      ST_T11:  state_nxt = t_bad ? ST_DONE : ST_T20;
      ST_T20:  state_nxt = ST_T21;
      ST_T21: begin
        bx_nxt = '0;
        by_nxt = '0;
        d_nxt  = '0;
        state_nxt = t_bad ? ST_DONE : ST_P0;
      end
      ST_P0: begin
        if (d_r == n_sat) begin
          state_nxt = ST_VX0;
        end else if ((d_r[3:0] == a_r) || (d_r[3:0] == b_r)) begin
          d_nxt = d_r + DIR_W'(1);
        end else begin
          state_nxt = ST_P1;
        end
      end
      ST_P1: begin
        idx_nxt   = sum[SH2F+IDX_W-1:SH2F] + IDX_W'(1);
        state_nxt = ST_P2;
      end
      ST_P2: begin
        bx_nxt = sum; state_nxt = ST_P3;
      end
      ST_P3: begin
        by_nxt = sum; d_nxt = d_r + DIR_W'(1); state_nxt = ST_P0;
      end
      ST_VX0: state_nxt = ST_VX1;
      ST_VX1: begin
        bx_nxt = sum; state_nxt = ST_VY0;
      end
      ST_VY0: state_nxt = ST_VY1;
      ST_VY1: begin
        by_nxt = sum; hit_nxt = 1'b1; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Corner sums with saturation; a miss gives zeros
  function automatic logic signed [VERT_W-1:0] sat_vert(input acc_t v);
    logic signed [VERT_W-1:0] r;
    if (v > acc_t'(4194303)) begin
      r = {1'b0, {(VERT_W-1){1'b1}}};
    end else if (v < -acc_t'(4194304)) begin
      r = {1'b1, {(VERT_W-1){1'b0}}};
    end else begin
      r = v[VERT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    if (hit_r) begin
      ov_nxt[0] = sat_vert(bx_r + acc_t'(ca_r) + acc_t'(cb_r));
      ov_nxt[1] = sat_vert(by_r + acc_t'(sa_r) + acc_t'(sb_r));
      ov_nxt[2] = sat_vert(bx_r + acc_t'(cb_r));
      ov_nxt[3] = sat_vert(by_r + acc_t'(sb_r));
      ov_nxt[4] = sat_vert(bx_r);
      ov_nxt[5] = sat_vert(by_r);
      ov_nxt[6] = sat_vert(bx_r + acc_t'(ca_r));
      ov_nxt[7] = sat_vert(by_r + acc_t'(sa_r));
    end else begin
      for (int i = 0; i < 8; i++) begin
        ov_nxt[i] = '0;
      end
    end
  end

  // Output register transfer
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    ja_r  <= ja_nxt;
    jb_r  <= jb_nxt;
    sa_r  <= sa_nxt;
    ca_r  <= ca_nxt;
    sb_r  <= sb_nxt;
    cb_r  <= cb_nxt;
    den_r <= den_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    bx_r  <= bx_nxt;
    by_r  <= by_nxt;
    idx_r <= idx_nxt;
    d_r   <= d_nxt;
    if (out_load) begin
      out_hit_r <= hit_r;
      for (int i = 0; i < 8; i++) begin
        ov_r[i] <= ov_nxt[i];
      end
    end
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_vert0_x = ov_r[0];
  assign out_vert0_y = ov_r[1];
  assign out_vert1_x = ov_r[2];
  assign out_vert1_y = ov_r[3];
  assign out_vert2_x = ov_r[4];
  assign out_vert2_y = ov_r[5];
  assign out_vert3_x = ov_r[6];
  assign out_vert3_y = ov_r[7];

endmodule

`default_nettype wire

/* design/mgrv_div.sv */
// ----------------------------------------------------------------------------
// mgrv_div: sequential fixed-point divider
// Computes floor(num * 2^12 / den) one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mgrv_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire mgrv_pkg::acc_t  num,
  input  wire mgrv_pkg::den_t  den,
  output logic                 done,
  output mgrv_pkg::quot_t      quot
);
  import mgrv_pkg::*;

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [QUOT_W-1:0]      low_r, low_nxt;
  logic [QUOT_W-1:0]      q_r, q_nxt;
  logic [DEN_W-1:0]       dn_r, dn_nxt;
  logic                   neg_r, neg_nxt;
  logic [ACC_W-1:0]       num_mag;
  logic [DEN_W-1:0]       den_mag;
  logic [REM_W-1:0]       rem_sh;
  logic [QUOT_W-1:0]      q_adj;

  // Magnitudes of the operands
  assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign rem_sh  = {rem_r[REM_W-2:0], low_r[QUOT_W-1]};

  // One restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    dn_nxt   = dn_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUOT_W);
      neg_nxt  = num[ACC_W-1] ^ den[DEN_W-1];
      dn_nxt   = den_mag;
      rem_nxt  = num_mag[ACC_W-1:FRAC_BITS];
      low_nxt  = {num_mag[FRAC_BITS-1:0], {(QUOT_W-FRAC_BITS){1'b0}}};
      q_nxt    = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dn_r}) begin
        rem_nxt = rem_sh - {1'b0, dn_r};
        q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
      end
      low_nxt = {low_r[QUOT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    dn_r  <= dn_nxt;
    neg_r <= neg_nxt;
  end

  // Negative quotients round toward minus infinity
  assign q_adj = q_r + QUOT_W'(rem_r != '0);
  assign quot  = neg_r ? quot_t'(-q_adj) : quot_t'(q_r);
  assign done  = done_r;

endmodule

`default_nettype wire

/* design/mgrv_mac.sv */
// ----------------------------------------------------------------------------
// mgrv_mac: shared multiply-accumulate unit
// Adds or subtracts one signed product to a selected base each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mgrv_mac (
  input  wire logic                clk,
  input  wire mgrv_pkg::mac_ctrl_t ctrl,
  input  wire mgrv_pkg::opa_t      op_a,
  input  wire mgrv_pkg::trig_t     op_b,
  input  wire mgrv_pkg::acc_t      ext_base,
  output mgrv_pkg::acc_t           sum
);
  import mgrv_pkg::*;

  localparam int PROD_W = OPA_W + TRIG_W;

  acc_t                     acc_r;
  logic signed [PROD_W-1:0] prod;
  acc_t                     prod_ext;
  acc_t                     base;

  assign prod     = op_a * op_b;
  assign prod_ext = acc_t'(prod);

  // Base of the accumulation
  always_comb begin
    unique case (ctrl.base_sel)
      BASE_ACC:  base = acc_r;
      BASE_EXT:  base = ext_base;
      default:   base = '0;
    endcase
  end

  assign sum = ctrl.neg ? base - prod_ext : base + prod_ext;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= sum;
    end
  end

endmodule

`default_nettype wire
